// ===== rtl/core/mbe_pkg.sv =====
`default_nettype none

package mbe_pkg;

  // default sizes of c and of the fixed-point format
  localparam int WORD_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 28;

  // iteration limit register
  localparam int                  LIMIT_W     = 16;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(256);

  // sequencer states: one multiplier pass per state for x*x, y*y and x*y
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_UPD
  } mbe_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mandelbrot_escape_test.sv =====
`default_nettype none

// Mandelbrot escape-time test for one point c = (in_cx, in_cy), signed fixed
// point with FRACTION_BITS fraction bits. Starting from z = 0 the block runs
// z = z*z + c up to iteration_limit times and answers out_inside_res = 1 if
// |z|^2 never exceeded 4, else 0 at the first escape. A point is taken on a
// clock edge with start high and busy low; busy then stays high until the
// answer is out. The answer on out_inside_res is marked by out_valid for
// exactly one cycle, and the receiver cannot stall it, so capture it then.
// All products go through one shared signed multiplier of FRACTION_BITS+3
// bits square, used in turn for x*x, y*y and x*y, then an update state ends
// the iteration. An inside point keeps busy high through all iterations up
// to the limit; an escaping point leaves at the first escape. The result
// strobe rises in the same cycle that busy falls, and a new point may be
// started in that cycle. A limit of zero answers inside with no update.
// iteration_limit (reset 256) is written through cfg_valid/cfg_data, always
// ready; it is written only while idle by the user, the block does not enforce it.
module mandelbrot_escape_test
  import mbe_pkg::*;
#(
  parameter int WORD_WIDTH    = WORD_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // point input
  input  wire                          start,
  output logic                         busy,
  input  wire  signed [WORD_WIDTH-1:0] in_cx,
  input  wire  signed [WORD_WIDTH-1:0] in_cy,
  // result strobe
  output logic                         out_valid,
  output logic                         out_inside_res,
  // iteration limit write
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire         [LIMIT_W-1:0]    cfg_data
);

  // multiplier operand width: a bounded z (|x|,|y| <= 2) fits in F+3 bits
  localparam int MW = FRACTION_BITS + 3;
  localparam int PW = 2 * MW;
  // working z width: holds cx + x*x - y*y and cy + 2*x*y with room to spare
  localparam int ZW = ((WORD_WIDTH > FRACTION_BITS + 7) ?
                       WORD_WIDTH : FRACTION_BITS + 7) + 2;

  localparam logic signed [ZW-1:0] TWO_Z   = ZW'(2) << FRACTION_BITS;
  localparam logic        [PW:0]   FOUR_SQ = (PW+1)'(1) << (2 * FRACTION_BITS + 2);

  mbe_state_t state_r, state_nxt;

  logic                         busy_r;
  logic signed [WORD_WIDTH-1:0] cx_r, cy_r;
  logic signed [ZW-1:0]         x_r, y_r, x_nxt, y_nxt;
  logic        [LIMIT_W-1:0]    cnt_r;
  logic        [LIMIT_W-1:0]    limit_r;
  logic signed [PW-1:0]         pxx_r, pyy_r, pxy_r;
  logic                         out_valid_r, out_inside_r;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  // escape and termination tests
  logic                 z_big;
  logic        [PW:0]   sq_sum;
  logic                 sq_esc;
  logic                 cnt_done;
  logic signed [ZW-1:0] xx_v, yy_v, xy2_v;

  // control decoded from the state
  logic done_now;
  logic inside_now;

  logic accept_item;
  assign accept_item = start && !busy_r;

  // z is out of the disk's bounding box: escape without the exact compare
  assign z_big = (x_r > TWO_Z) || (x_r < -TWO_Z) || (y_r > TWO_Z) || (y_r < -TWO_Z);

  // exact |z|^2 at 2F fraction bits; both squares are non-negative
  assign sq_sum   = (PW+1)'($unsigned(pxx_r)) + (PW+1)'($unsigned(pyy_r));
  assign sq_esc   = sq_sum > FOUR_SQ;
  assign cnt_done = (cnt_r == limit_r);

  // floor-truncated products, values small enough to fit the working width
  assign xx_v  = ZW'(pxx_r >>> FRACTION_BITS);
  assign yy_v  = ZW'(pyy_r >>> FRACTION_BITS);
  assign xy2_v = ZW'(pxy_r >>> (FRACTION_BITS - 1));

  assign x_nxt = xx_v - yy_v + ZW'(cx_r);
  assign y_nxt = xy2_v + ZW'(cy_r);

  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_XX;
      end
      ST_XX: begin
        if (z_big) state_nxt = ST_IDLE;
        else       state_nxt = ST_YY;
      end
      ST_YY: state_nxt = ST_XY;
      ST_XY: begin
        if (sq_esc || cnt_done) state_nxt = ST_IDLE;
        else                    state_nxt = ST_UPD;
      end
      ST_UPD:  state_nxt = ST_XX;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operands and completion
  always_comb begin
    mul_a      = x_r[MW-1:0];
    mul_b      = x_r[MW-1:0];
    done_now   = 1'b0;
    inside_now = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_XX: begin
        // x*x; a huge z ends the point here
        done_now = z_big;
      end
      ST_YY: begin
        mul_a = y_r[MW-1:0];
        mul_b = y_r[MW-1:0];
      end
      ST_XY: begin
        mul_b      = y_r[MW-1:0];
        done_now   = sq_esc || cnt_done;
        inside_now = !sq_esc;
      end
      ST_UPD:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= 1'b0;
      limit_r      <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
      out_inside_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != ST_IDLE);
      out_valid_r <= done_now;
      if (done_now) out_inside_r <= inside_now;
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      if (accept_item)            cnt_r <= '0;
      else if (state_r == ST_UPD) cnt_r <= cnt_r + LIMIT_W'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_item) begin
      cx_r <= in_cx;
      cy_r <= in_cy;
      x_r  <= '0;
      y_r  <= '0;
    end else if (state_r == ST_UPD) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
    unique case (state_r)
      ST_XX:   pxx_r <= mul_p;
      ST_YY:   pyy_r <= mul_p;
      ST_XY:   pxy_r <= mul_p;
      default: ;
    endcase
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign cfg_ready      = 1'b1;

  // the iteration count never runs past the limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= limit_r))
    else $error("iteration count beyond limit");

  // an answer always comes with the block back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!busy_r && state_r == ST_IDLE))
    else $error("result while still busy");

  // an inside answer only after all iterations were done
  a_inside_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inside_r) |-> $past(cnt_done && state_r == ST_XY))
    else $error("inside answer before limit reached");

  // a started point makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept_item |=> busy_r)
    else $error("start not taken");

  // busy mirrors the sequencer
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != ST_IDLE))
    else $error("busy out of step with sequencer");

endmodule

`default_nettype wire

// ===== test/mandelbrot_escape_test_test.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_test_test;
  import mbe_pkg::*;

  localparam int WORD_W = WORD_WIDTH_DEF;
  localparam int FRAC   = FRACTION_BITS_DEF;

  // escape radius in the z format, and radius squared at twice the fraction bits
  localparam logic signed [63:0]  TWO_FX   = 64'sd2 <<< FRAC;
  localparam logic signed [127:0] FOUR_SQR = 128'sd4 <<< (2 * FRAC);

  // count of random limit settings in the last stretch of the run
  localparam int RANDOM_LIMITS = 14;

  // tracks the iteration limit and the answers still owed by the block
  class escape_scoreboard;
    logic [LIMIT_W-1:0] limit;
    bit                 answer_q[$];
    int                 errors;
    int                 n_points;
    int                 n_answers;
    int                 n_inside;

    function new();
      limit = LIMIT_RESET;
    endfunction

    // runs z = z*z + c at most limit times; 1 if z never left the disk
    function bit stays_bounded(logic signed [WORD_W-1:0] cx,
                               logic signed [WORD_W-1:0] cy);
      logic signed [63:0]  x;
      logic signed [63:0]  y;
      logic signed [63:0]  cxw;
      logic signed [63:0]  cyw;
      logic signed [127:0] sq_x;
      logic signed [127:0] sq_y;
      logic signed [127:0] prod_xy;
      logic signed [127:0] mag_sq;
      int                  i;
      x   = '0;
      y   = '0;
      cxw = cx;
      cyw = cy;
      for (i = 0; i < limit; i++) begin
        sq_x    = x * x;
        sq_y    = y * y;
        prod_xy = x * y;
        // arithmetic shifts floor the products; one bit less doubles x*y
        x = (sq_x >>> FRAC) - (sq_y >>> FRAC) + cxw;
        y = (prod_xy >>> (FRAC - 1)) + cyw;
        // a coordinate beyond 2 is out without the squared compare
        if (x > TWO_FX || x < -TWO_FX || y > TWO_FX || y < -TWO_FX) return 1'b0;
        mag_sq = x * x + y * y;
        if (mag_sq > FOUR_SQR) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_point(logic signed [WORD_W-1:0] cx, logic signed [WORD_W-1:0] cy);
      answer_q.push_back(stays_bounded(cx, cy));
      n_points++;
    endfunction

    function void check_answer(logic got);
      bit want;
      if (answer_q.size() == 0) begin
        $error("inside_res: answer with no point pending, got %0b", got);
        errors++;
        return;
      end
      want = answer_q.pop_front();
      n_answers++;
      if (got === 1'b1) n_inside++;
      if (got !== want) begin
        $error("inside_res: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [WORD_W-1:0] in_cx;
  logic signed [WORD_W-1:0] in_cy;
  logic                     out_valid;
  logic                     out_inside_res;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [LIMIT_W-1:0]       cfg_data;

  escape_scoreboard sb;
  // when clear, the sender stops idling between points
  bit gaps_on = 1'b1;

  mandelbrot_escape_test dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cx         (in_cx),
    .in_cy         (in_cy),
    .out_valid     (out_valid),
    .out_inside_res(out_inside_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // values read here are the ones from before the edge, so the block's own
  // updates at this edge cannot leak in
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.limit = cfg_data;
      if (start && !busy) sb.note_point(in_cx, in_cy);
      if (out_valid) sb.check_answer(out_inside_res);
    end
  end

  // point at the given value in thousandths
  function automatic logic signed [WORD_W-1:0] fix_milli(int m);
    return WORD_W'((longint'(m) * (longint'(1) <<< FRAC)) / 1000);
  endfunction

  // start stays high from one transfer to the next when no gap is drawn
  task automatic send_point(input logic signed [WORD_W-1:0] cx,
                            input logic signed [WORD_W-1:0] cy);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cx <= cx;
    in_cy <= cy;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender holds off until every owed answer is in and the block is idle
  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.answer_q.size() != 0 || busy);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_points(input int count);
    int                       n;
    int                       kind;
    logic signed [WORD_W-1:0] cx;
    logic signed [WORD_W-1:0] cy;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // box around the set, where orbits run long
        cx = fix_milli(-2100) + WORD_W'($urandom_range(0, 32'(fix_milli(2700))));
        cy = fix_milli(-1300) + WORD_W'($urandom_range(0, 32'(fix_milli(2600))));
      end else if (kind < 85) begin
        // anything the fields allow, mostly gone on the first update
        cx = $urandom;
        cy = $urandom;
      end else if (kind < 93) begin
        // within 1024 ulps of zero, exercising floor on negative products
        cx = int'($urandom_range(0, 2047)) - 1024;
        cy = int'($urandom_range(0, 2047)) - 1024;
      end else begin
        // a hair around the radius-2 circle on an axis
        cx = WORD_W'(($urandom_range(0, 1) ? TWO_FX : -TWO_FX) +
                     int'($urandom_range(0, 4)) - 2);
        cy = int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) begin
          cx = cx ^ cy;
          cy = cx ^ cy;
          cx = cx ^ cy;
        end
      end
      send_point(cx, cy);
    end
  endtask

  initial begin
    int k;
    start     = 1'b0;
    in_cx     = '0;
    in_cy     = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    sb        = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // corner points at the reset limit
    send_point(fix_milli(0), fix_milli(0));          // origin, stays put
    send_point(fix_milli(-2000), fix_milli(0));      // tip: |x| sits at exactly 2
    send_point(fix_milli(-2000), -1);                // tip nudged off the axis
    send_point(fix_milli(250), fix_milli(0));        // cusp
    send_point(fix_milli(250) + (1 <<< 16), 0);      // just past the cusp, slow escape
    send_point(fix_milli(0), fix_milli(1000));       // i, a cycle of period two
    send_point(fix_milli(0), fix_milli(1000) + 1);   // one ulp above i
    send_point(fix_milli(-1000), fix_milli(0));      // period-two bulb
    send_point(fix_milli(-750), fix_milli(100));     // neck between the bulbs
    send_point(fix_milli(2000), fix_milli(0));       // on the radius, out on the next update
    send_point(fix_milli(2000) + 1, fix_milli(0));   // coordinate just past 2
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff);      // field maxima
    send_point(32'sh8000_0000, 32'sh8000_0000);      // field minima
    send_point(32'sh8000_0000, 32'sh7fff_ffff);
    send_point(32'sh7fff_ffff, 32'sh8000_0000);
    send_point(fix_milli(0), fix_milli(-2000));      // imaginary axis at -2
    send_point(fix_milli(1500), fix_milli(1500));    // both coordinates in range, radius out
    send_point(fix_milli(-1500), fix_milli(-1500));
    send_point(fix_milli(300), fix_milli(-500));
    send_point(-1, -1);                              // one ulp below zero on both axes

    // zero limit answers inside right away
    write_limit('0);
    send_random_points(40);
    write_limit(LIMIT_W'(1));
    send_random_points(60);
    write_limit(LIMIT_W'(2));
    send_random_points(60);

    // largest limit: one long bounded orbit, the rest leave quickly
    write_limit('1);
    send_point(fix_milli(0), fix_milli(0));
    send_point(fix_milli(260), fix_milli(0));
    send_point($urandom, $urandom);
    send_point($urandom, $urandom);
    send_point(fix_milli(3000), fix_milli(-3000));
    send_point(fix_milli(-7000), fix_milli(500));

    write_limit(LIMIT_RESET);
    send_random_points(60);

    for (k = 0; k < RANDOM_LIMITS; k++) begin
      write_limit(LIMIT_W'($urandom_range(3, 64)));
      // roughly one phase in four runs back to back
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_points(70);
    end

    wait_drain();
    // a stray strobe would show up while the bench waits here after going idle
    repeat (16) @(posedge clk);
    if (sb.answer_q.size() != 0) begin
      $error("inside_res: %0d answers never arrived", sb.answer_q.size());
      sb.errors++;
    end
    $display("%0d points through, %0d answers compared (%0d inside, %0d escaped)",
             sb.n_points, sb.n_answers, sb.n_inside, sb.n_answers - sb.n_inside);
    $display("limits covered: 0, 1, 2, 65535, reset value and %0d random settings",
             RANDOM_LIMITS);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #(100_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mbe_pkg.sv
rtl/core/mandelbrot_escape_test.sv
test/mandelbrot_escape_test_test.sv
